[hdl/biq_pkg.sv]
package biq_pkg;

    // default formats: sample Q1.23, coefficient Q4.28, delay state Q8.40
    localparam int DEF_SAMPLE_WIDTH = 24;
    localparam int DEF_COEF_WIDTH   = 32;
    localparam int DEF_STATE_WIDTH  = 48;

    // number of coefficient registers
    localparam int NUM_COEF = 5;

    // coefficient register indexes
    typedef enum logic [2:0] {
        COEF_FEED_ZERO = 3'd0,
        COEF_FEED_ONE  = 3'd1,
        COEF_FEED_TWO  = 3'd2,
        COEF_BACK_ONE  = 3'd3,
        COEF_BACK_TWO  = 3'd4
    } t_coef_idx;

    // first multiplier operand: input sample, low or high half of y_full
    typedef enum logic [1:0] {
        OPA_X   = 2'd0,
        OPA_YLO = 2'd1,
        OPA_YHI = 2'd2
    } t_opa_sel;

    // sequencer states, one multiply issued in each of P0 through F2HI
    typedef enum logic [3:0] {
        ST_IDLE  = 4'd0,
        ST_P0    = 4'd1,
        ST_P1    = 4'd2,
        ST_P2    = 4'd3,
        ST_F1LO  = 4'd4,
        ST_F1HI  = 4'd5,
        ST_F2LO  = 4'd6,
        ST_F2HI  = 4'd7,
        ST_ACC2  = 4'd8,
        ST_DONE  = 4'd9
    } t_state;

    // commands from the sequencer to the datapath
    typedef struct packed {
        logic      load_x;
        t_opa_sel  opa;
        t_coef_idx coef;
        logic      ld_y;
        logic      ld_t1;
        logic      ld_t2;
        logic      acc_lo;
        logic      acc_hi;
        logic      ld_d1;
        logic      ld_d2;
        logic      ld_out;
    } t_cmd;

    // status from the datapath to the sequencer
    typedef struct packed {
        logic out_stall;
    } t_stat;

endpackage

[hdl/biq_cfg_regs.sv]
module biq_cfg_regs #(
    parameter int COEF_WIDTH = biq_pkg::DEF_COEF_WIDTH,
    parameter int DATA_WIDTH = 32,
    parameter int ADDR_WIDTH = 5
) (
    input  logic                                          i_clk,
    input  logic                                          i_rst_n,
    input  logic                                          psel,
    input  logic                                          penable,
    input  logic                                          pwrite,
    input  logic [ADDR_WIDTH-1:0]                         paddr,
    input  logic [DATA_WIDTH-1:0]                         pwdata,
    output logic [DATA_WIDTH-1:0]                         prdata,
    output logic                                          pready,
    output logic [biq_pkg::NUM_COEF-1:0][COEF_WIDTH-1:0]  o_coef
);

    // unity gain in Q4.28 style format
    localparam logic [COEF_WIDTH-1:0] COEF_ONE =
        {{(COEF_WIDTH-1){1'b0}}, 1'b1} << (COEF_WIDTH - 4);

    // reset image: feed_zero at unity, all other coefficients zero
    localparam logic [biq_pkg::NUM_COEF-1:0][COEF_WIDTH-1:0] COEF_RST =
        {{((biq_pkg::NUM_COEF-1)*COEF_WIDTH){1'b0}}, COEF_ONE};

    logic [biq_pkg::NUM_COEF-1:0][COEF_WIDTH-1:0] r_coef;
    logic [2:0]                                   w_idx;
    logic                                         w_wr;

    // register index from the word address
    assign w_idx  = paddr[ADDR_WIDTH-1 -: 3];
    assign w_wr   = psel && penable && pwrite;
    assign pready = 1'b1;

    // coefficient write, indexes past the last register are dropped
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_coef <= COEF_RST;
        end else if (w_wr && (w_idx < 3'(biq_pkg::NUM_COEF))) begin
            r_coef[w_idx] <= pwdata[COEF_WIDTH-1:0];
        end
    end

    // read back
    always_comb begin
        if (w_idx < 3'(biq_pkg::NUM_COEF)) begin
            prdata = DATA_WIDTH'(r_coef[w_idx]);
        end else begin
            prdata = '0;
        end
    end

    assign o_coef = r_coef;

endmodule

[hdl/biq_ctrl.sv]
module biq_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    output logic            o_ready,
    output biq_pkg::t_cmd   o_cmd,
    input  biq_pkg::t_stat  i_stat
);

    biq_pkg::t_state r_state;
    biq_pkg::t_state n_state;

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= biq_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            biq_pkg::ST_IDLE: begin
                if (i_valid) begin
                    n_state = biq_pkg::ST_P0;
                end
            end
            biq_pkg::ST_P0:   n_state = biq_pkg::ST_P1;
            biq_pkg::ST_P1:   n_state = biq_pkg::ST_P2;
            biq_pkg::ST_P2:   n_state = biq_pkg::ST_F1LO;
            biq_pkg::ST_F1LO: n_state = biq_pkg::ST_F1HI;
            biq_pkg::ST_F1HI: n_state = biq_pkg::ST_F2LO;
            biq_pkg::ST_F2LO: n_state = biq_pkg::ST_F2HI;
            biq_pkg::ST_F2HI: n_state = biq_pkg::ST_ACC2;
            biq_pkg::ST_ACC2: n_state = biq_pkg::ST_DONE;
            biq_pkg::ST_DONE: begin
                if (!i_stat.out_stall) begin
                    n_state = biq_pkg::ST_IDLE;
                end
            end
            default:          n_state = biq_pkg::ST_IDLE;
        endcase
    end

    // datapath commands
    always_comb begin
        o_cmd      = '0;
        o_cmd.opa  = biq_pkg::OPA_X;
        o_cmd.coef = biq_pkg::COEF_FEED_ZERO;
        o_ready    = 1'b0;
        case (r_state)
            biq_pkg::ST_IDLE: begin
                o_ready      = 1'b1;
                o_cmd.load_x = i_valid;
            end
            biq_pkg::ST_P0: begin
                o_cmd.coef = biq_pkg::COEF_FEED_ZERO;
            end
            biq_pkg::ST_P1: begin
                o_cmd.coef = biq_pkg::COEF_FEED_ONE;
                o_cmd.ld_y = 1'b1;
            end
            biq_pkg::ST_P2: begin
                o_cmd.coef  = biq_pkg::COEF_FEED_TWO;
                o_cmd.ld_t1 = 1'b1;
            end
            biq_pkg::ST_F1LO: begin
                o_cmd.opa   = biq_pkg::OPA_YLO;
                o_cmd.coef  = biq_pkg::COEF_BACK_ONE;
                o_cmd.ld_t2 = 1'b1;
            end
            biq_pkg::ST_F1HI: begin
                o_cmd.opa    = biq_pkg::OPA_YHI;
                o_cmd.coef   = biq_pkg::COEF_BACK_ONE;
                o_cmd.acc_lo = 1'b1;
            end
            biq_pkg::ST_F2LO: begin
                o_cmd.opa    = biq_pkg::OPA_YLO;
                o_cmd.coef   = biq_pkg::COEF_BACK_TWO;
                o_cmd.acc_hi = 1'b1;
            end
            biq_pkg::ST_F2HI: begin
                o_cmd.opa    = biq_pkg::OPA_YHI;
                o_cmd.coef   = biq_pkg::COEF_BACK_TWO;
                o_cmd.ld_d1  = 1'b1;
                o_cmd.acc_lo = 1'b1;
            end
            biq_pkg::ST_ACC2: begin
                o_cmd.acc_hi = 1'b1;
            end
            biq_pkg::ST_DONE: begin
                o_cmd.ld_d2  = !i_stat.out_stall;
                o_cmd.ld_out = !i_stat.out_stall;
            end
            default: begin
                o_ready = 1'b0;
            end
        endcase
    end

    // an accepted item starts the multiply sequence
    a_accept_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && o_ready) |=> (r_state == biq_pkg::ST_P0))
        else $error("accepted item did not start the sequence");

    // the result register is never overwritten while still held
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.ld_out |-> !i_stat.out_stall)
        else $error("result written while output stalled");

    // at most one state or partial-sum load per cycle
    a_one_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0({o_cmd.ld_y, o_cmd.ld_t1, o_cmd.ld_t2, o_cmd.ld_d1, o_cmd.ld_d2}))
        else $error("conflicting datapath loads");

endmodule

[hdl/biq_datapath.sv]
module biq_datapath #(
    parameter int SAMPLE_WIDTH = biq_pkg::DEF_SAMPLE_WIDTH,
    parameter int COEF_WIDTH   = biq_pkg::DEF_COEF_WIDTH,
    parameter int STATE_WIDTH  = biq_pkg::DEF_STATE_WIDTH
) (
    input  logic                                          i_clk,
    input  logic                                          i_rst_n,
    input  biq_pkg::t_cmd                                 i_cmd,
    output biq_pkg::t_stat                                o_stat,
    input  logic [SAMPLE_WIDTH-1:0]                       i_sample,
    input  logic [biq_pkg::NUM_COEF-1:0][COEF_WIDTH-1:0]  i_coef,
    input  logic                                          i_out_ready,
    output logic                                          o_out_valid,
    output logic [SAMPLE_WIDTH-1:0]                       o_sample
);

    localparam int X = SAMPLE_WIDTH;
    localparam int C = COEF_WIDTH;
    localparam int S = STATE_WIDTH;
    // product rescale: sample*coef fraction bits minus state fraction bits
    localparam int PSH     = X + C - S + 3;
    localparam int PSH_R   = (PSH > 0) ? PSH : 0;
    localparam int PSH_L   = (PSH < 0) ? -PSH : 0;
    localparam int PSH_RM1 = (PSH_R > 0) ? PSH_R - 1 : 0;
    // rescaled feedforward product and y_full widths
    localparam int PW  = X + C - PSH_R + PSH_L;
    localparam int YW  = ((PW > S) ? PW : S) + 1;
    // y_full split into an unsigned low half and a signed high half
    localparam int L   = YW - YW / 2;
    localparam int AW  = (X > L + 1) ? X : L + 1;
    localparam int MW  = AW + C;
    localparam int TW  = ((MW + PSH_L > S + PSH_R) ? MW + PSH_L : S + PSH_R) + 2;
    // feedback product accumulator
    localparam int FW  = YW + C;
    localparam int CF  = C - 4;
    localparam int GW  = FW - CF;
    localparam int DW2 = GW + 2;
    // y_full to sample format
    localparam int OSH = S - X - 7;
    localparam int YW1 = YW + 1;
    localparam int OW  = YW1 - OSH;

    localparam logic [TW-1:0]  RND_P = {{(TW-1){1'b0}}, (PSH_R > 0)} << PSH_RM1;
    localparam logic [FW-1:0]  RND_F = {{(FW-1){1'b0}}, 1'b1} << (CF - 1);
    localparam logic [YW1-1:0] RND_O = {{(YW1-1){1'b0}}, 1'b1} << (OSH - 1);

    logic signed [X-1:0]   r_x;
    logic signed [MW-1:0]  r_prod;
    logic signed [YW-1:0]  r_y;
    logic signed [YW-1:0]  r_t1;
    logic signed [YW-1:0]  r_t2;
    logic signed [FW-1:0]  r_acc;
    logic signed [S-1:0]   r_d1;
    logic signed [S-1:0]   r_d2;
    logic [X-1:0]          r_out;
    logic                  r_out_valid;

    logic signed [AW-1:0]  w_opa;
    logic signed [C-1:0]   w_coef;
    logic signed [S-1:0]   w_addend;
    logic signed [TW-1:0]  w_sum_p;
    logic signed [GW-1:0]  w_fb;
    logic signed [YW-1:0]  w_tsel;
    logic signed [DW2-1:0] w_diff;
    logic [DW2-S:0]        w_dtop;
    logic signed [S-1:0]   w_dsat;
    logic signed [YW1-1:0] w_yr;
    logic [OW-1:0]         w_yq;
    logic [OW-X:0]         w_ytop;
    logic [X-1:0]          w_ysat;

    // multiplier operand select
    always_comb begin
        case (i_cmd.opa)
            biq_pkg::OPA_X:   w_opa = AW'(r_x);
            biq_pkg::OPA_YLO: w_opa = $signed(AW'({1'b0, r_y[L-1:0]}));
            biq_pkg::OPA_YHI: w_opa = AW'($signed(r_y[YW-1:L]));
            default:          w_opa = '0;
        endcase
    end

    always_comb begin
        case (i_cmd.coef)
            biq_pkg::COEF_FEED_ZERO: w_coef = $signed(i_coef[biq_pkg::COEF_FEED_ZERO]);
            biq_pkg::COEF_FEED_ONE:  w_coef = $signed(i_coef[biq_pkg::COEF_FEED_ONE]);
            biq_pkg::COEF_FEED_TWO:  w_coef = $signed(i_coef[biq_pkg::COEF_FEED_TWO]);
            biq_pkg::COEF_BACK_ONE:  w_coef = $signed(i_coef[biq_pkg::COEF_BACK_ONE]);
            biq_pkg::COEF_BACK_TWO:  w_coef = $signed(i_coef[biq_pkg::COEF_BACK_TWO]);
            default:                 w_coef = '0;
        endcase
    end

    // shared multiplier, registered product
    always_ff @(posedge i_clk) begin
        r_prod <= w_opa * w_coef;
        if (i_cmd.load_x) begin
            r_x <= $signed(i_sample);
        end
    end

    // feedforward product rounded to state format, plus d1 for y, d2 for t1, nothing for t2
    always_comb begin
        if (i_cmd.ld_y) begin
            w_addend = r_d1;
        end else if (i_cmd.ld_t1) begin
            w_addend = r_d2;
        end else begin
            w_addend = '0;
        end
    end

    assign w_sum_p = (TW'(r_prod) <<< PSH_L) + $signed(RND_P) + (TW'(w_addend) <<< PSH_R);

    always_ff @(posedge i_clk) begin
        if (i_cmd.ld_y) begin
            r_y <= $signed(w_sum_p[PSH_R +: YW]);
        end
        if (i_cmd.ld_t1) begin
            r_t1 <= $signed(w_sum_p[PSH_R +: YW]);
        end
        if (i_cmd.ld_t2) begin
            r_t2 <= $signed(w_sum_p[PSH_R +: YW]);
        end
    end

    // feedback product built from two partial products, then rounding bias
    always_ff @(posedge i_clk) begin
        if (i_cmd.acc_lo) begin
            r_acc <= FW'(r_prod);
        end else if (i_cmd.acc_hi) begin
            r_acc <= r_acc + (FW'(r_prod) <<< L) + $signed(RND_F);
        end
    end

    // new delay value with saturation
    assign w_fb   = $signed(r_acc[FW-1:CF]);
    assign w_tsel = i_cmd.ld_d1 ? r_t1 : r_t2;
    assign w_diff = DW2'(w_tsel) - DW2'(w_fb);
    assign w_dtop = w_diff[DW2-1:S-1];

    always_comb begin
        if ((&w_dtop) || !(|w_dtop)) begin
            w_dsat = w_diff[S-1:0];
        end else begin
            w_dsat = {w_diff[DW2-1], {(S-1){~w_diff[DW2-1]}}};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_d1 <= '0;
            r_d2 <= '0;
        end else begin
            if (i_cmd.ld_d1) begin
                r_d1 <= w_dsat;
            end
            if (i_cmd.ld_d2) begin
                r_d2 <= w_dsat;
            end
        end
    end

    // y_full rounded to sample format and saturated
    assign w_yr   = YW1'(r_y) + $signed(RND_O);
    assign w_yq   = w_yr[YW1-1:OSH];
    assign w_ytop = w_yq[OW-1:X-1];

    always_comb begin
        if ((&w_ytop) || !(|w_ytop)) begin
            w_ysat = w_yq[X-1:0];
        end else begin
            w_ysat = {w_yq[OW-1], {(X-1){~w_yq[OW-1]}}};
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (i_cmd.ld_out) begin
            r_out <= w_ysat;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.ld_out) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_stat.out_stall = r_out_valid && !i_out_ready;
    assign o_out_valid      = r_out_valid;
    assign o_sample         = r_out;

endmodule

[hdl/biquad_iir_filter_unit.sv]
// Second-order IIR section, transposed direct form II. Each item on the
// s_axis side is one signed Q1.23 sample; each item on m_axis is the
// filtered sample, rounded and saturated to Q1.23. Five signed Q4.28
// coefficients (b0, b1, b2, a1, a2; a1 and a2 are subtracted) sit on the
// APB port at byte addresses 0x00..0x10 and reset to a pass-through
// filter. The two Q8.40 delay states reset to zero and saturate. Once
// a sample is accepted, a single shared multiplier works through seven
// products (three feedforward, and two feedback products each split
// into two halves of y_full). The next sample is accepted only after
// the result is loaded, which is held back while a previous result
// waits unread on m_axis. Change coefficients only while no sample is
// in flight.
module biquad_iir_filter_unit #(
    parameter int SAMPLE_WIDTH = biq_pkg::DEF_SAMPLE_WIDTH,
    parameter int COEF_WIDTH   = biq_pkg::DEF_COEF_WIDTH,
    parameter int STATE_WIDTH  = biq_pkg::DEF_STATE_WIDTH,
    localparam int TDW         = ((SAMPLE_WIDTH + 7) / 8) * 8,
    localparam int PDW         = (COEF_WIDTH > 32) ? 64 : 32,
    localparam int PAW         = (COEF_WIDTH > 32) ? 6 : 5
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    // stream in
    input  logic           s_axis_tvalid,
    output logic           s_axis_tready,
    input  logic [TDW-1:0] s_axis_tdata,   // sample_in
    // stream out
    output logic           m_axis_tvalid,
    input  logic           m_axis_tready,
    output logic [TDW-1:0] m_axis_tdata,   // sample_out
    // register port
    input  logic           psel,
    input  logic           penable,
    input  logic           pwrite,
    input  logic [PAW-1:0] paddr,
    input  logic [PDW-1:0] pwdata,
    output logic [PDW-1:0] prdata,
    output logic           pready
);

    logic [biq_pkg::NUM_COEF-1:0][COEF_WIDTH-1:0] w_coef;
    biq_pkg::t_cmd                                w_cmd;
    biq_pkg::t_stat                               w_stat;
    logic [SAMPLE_WIDTH-1:0]                      w_sample_out;

    // coefficient registers
    biq_cfg_regs #(
        .COEF_WIDTH (COEF_WIDTH),
        .DATA_WIDTH (PDW),
        .ADDR_WIDTH (PAW)
    ) u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_coef  (w_coef)
    );

    // sequencer
    biq_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s_axis_tvalid),
        .o_ready (s_axis_tready),
        .o_cmd   (w_cmd),
        .i_stat  (w_stat)
    );

    // arithmetic and delay state
    biq_datapath #(
        .SAMPLE_WIDTH (SAMPLE_WIDTH),
        .COEF_WIDTH   (COEF_WIDTH),
        .STATE_WIDTH  (STATE_WIDTH)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd),
        .o_stat      (w_stat),
        .i_sample    (s_axis_tdata[SAMPLE_WIDTH-1:0]),
        .i_coef      (w_coef),
        .i_out_ready (m_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .o_sample    (w_sample_out)
    );

    assign m_axis_tdata = TDW'(w_sample_out);

endmodule

[tb/sv/biquad_iir_filter_unit_tb.sv]
`timescale 1ns / 1ps

module biquad_iir_filter_unit_tb;

    localparam int SW  = biq_pkg::DEF_SAMPLE_WIDTH;
    localparam int CW  = biq_pkg::DEF_COEF_WIDTH;
    localparam int STW = biq_pkg::DEF_STATE_WIDTH;
    localparam int TDW = ((SW + 7) / 8) * 8;
    localparam int PDW = 32;
    localparam int PAW = 5;

    // fraction bits of sample, coefficient and delay state
    localparam int XFRAC = SW - 1;
    localparam int CFRAC = CW - 4;
    localparam int SFRAC = STW - 8;

    localparam int HALF_PERIOD    = 6;
    localparam int RESET_CYCLES   = 5;
    localparam int SETTLE_CYCLES  = 12;
    localparam int TAIL_CYCLES    = 30;
    localparam int HOLD_CYCLES    = 300;
    localparam int WATCHDOG_LIMIT = 3000;
    localparam int PHASE_ITEMS    = 160;
    localparam int NUM_PHASES     = 8;
    localparam int MAX_REPORTS    = 40;
    localparam int LAST_REG_IDX   = 7;

    localparam int ONE_Q    = 1 << CFRAC;
    localparam int A2_LIMIT = ONE_Q / 20 * 19;

    localparam logic [CW-1:0] COEF_ONE = ONE_Q;
    localparam logic [CW-1:0] COEF_MAX = {1'b0, {(CW-1){1'b1}}};
    localparam logic [CW-1:0] COEF_MIN = {1'b1, {(CW-1){1'b0}}};
    localparam logic [SW-1:0] SMP_MAX  = {1'b0, {(SW-1){1'b1}}};
    localparam logic [SW-1:0] SMP_MIN  = {1'b1, {(SW-1){1'b0}}};

    typedef logic signed [127:0] t_wide;

    typedef enum {ROW_WRITE, ROW_SAMPLE} t_row_kind;

    typedef enum {STYLE_UNITY, STYLE_EXTREME, STYLE_STABLE, STYLE_FULL} t_coef_style;

    typedef struct {
        t_row_kind      kind;
        int unsigned    idx;
        logic [CW-1:0]  value;
        bit             known;
        logic [SW-1:0]  want;
    } t_row;

    typedef struct {
        logic [SW-1:0] model;
        bit            known;
        logic [SW-1:0] typed;
    } t_expect;

    logic           i_clk = 1'b0;
    logic           i_rst_n;
    logic           s_axis_tvalid;
    logic           s_axis_tready;
    logic [TDW-1:0] s_axis_tdata;
    logic           m_axis_tvalid;
    logic           m_axis_tready;
    logic [TDW-1:0] m_axis_tdata;
    logic           psel;
    logic           penable;
    logic           pwrite;
    logic [PAW-1:0] paddr;
    logic [PDW-1:0] pwdata;
    logic [PDW-1:0] prdata;
    logic           pready;

    // filter model: coefficients and the two delay states
    logic signed [CW-1:0]  tap_coef [biq_pkg::NUM_COEF];
    logic signed [STW-1:0] state_one;
    logic signed [STW-1:0] state_two;

    t_expect       filtered_q [$];
    t_row          plan [$];
    int            errors = 0;
    int            reports = 0;
    int            idle_cycles = 0;
    bit            hold_req = 1'b0;
    bit            rush = 1'b0;
    bit            smooth = 1'b0;
    bit            next_known = 1'b0;
    logic [SW-1:0] next_typed = '0;

    always #(HALF_PERIOD) i_clk = ~i_clk;

    biquad_iir_filter_unit dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),   // sample_in
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),   // sample_out
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    // rescale by 2^-n, rounding half up
    function automatic t_wide round_shift(input t_wide v, input int n);
        t_wide half;
        if (n <= 0) begin
            return v <<< (-n);
        end
        half = 1;
        half = half <<< (n - 1);
        return (v + half) >>> n;
    endfunction

    function automatic t_wide clamp(input t_wide v, input int w);
        t_wide top;
        t_wide bot;
        top = 1;
        top = (top <<< (w - 1)) - 1;
        bot = -top - 1;
        if (v > top) begin
            return top;
        end else if (v < bot) begin
            return bot;
        end
        return v;
    endfunction

    // one step of the transposed direct form II section
    function automatic logic [SW-1:0] filter_sample(input logic [SW-1:0] raw);
        logic signed [SW-1:0] xs;
        t_wide x, b0, b1, b2, a1, a2;
        t_wide p0, p1, p2, yfull, f1, f2, y, d1, d2;
        xs = raw;
        x  = xs;
        b0 = tap_coef[biq_pkg::COEF_FEED_ZERO];
        b1 = tap_coef[biq_pkg::COEF_FEED_ONE];
        b2 = tap_coef[biq_pkg::COEF_FEED_TWO];
        a1 = tap_coef[biq_pkg::COEF_BACK_ONE];
        a2 = tap_coef[biq_pkg::COEF_BACK_TWO];
        p0 = round_shift(x * b0, XFRAC + CFRAC - SFRAC);
        p1 = round_shift(x * b1, XFRAC + CFRAC - SFRAC);
        p2 = round_shift(x * b2, XFRAC + CFRAC - SFRAC);
        yfull = p0 + state_one;
        // feedback works on the unsaturated output
        f1 = round_shift(yfull * a1, CFRAC);
        f2 = round_shift(yfull * a2, CFRAC);
        y  = clamp(round_shift(yfull, SFRAC - XFRAC), SW);
        d1 = clamp(p1 + state_two - f1, STW);
        d2 = clamp(p2 - f2, STW);
        state_one = d1[STW-1:0];
        state_two = d2[STW-1:0];
        return y[SW-1:0];
    endfunction

    task automatic report_mismatch(input string what, input logic [PDW-1:0] got,
                                   input logic [PDW-1:0] want);
        errors++;
        if (reports < MAX_REPORTS) begin
            reports++;
            $display("mismatch on %s at %0t: got %h, expected %h", what, $time, got, want);
        end
    endtask

    // gap length: mostly none or short, a few long
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 45) begin
            return 0;
        end else if (r < 85) begin
            return $urandom_range(1, 3);
        end else if (r < 97) begin
            return $urandom_range(4, 12);
        end
        return $urandom_range(20, 60);
    endfunction

    function automatic logic [SW-1:0] pick_sample();
        int r;
        r = $urandom_range(0, 99);
        if (r < 6) begin
            return SMP_MAX;
        end else if (r < 12) begin
            return SMP_MIN;
        end else if (r < 30) begin
            return SW'(int'($urandom_range(0, 8191)) - 4096);
        end
        return SW'($urandom);
    endfunction

    function automatic logic [CW-1:0] pick_extreme();
        case ($urandom_range(0, 6))
            0: return COEF_MAX;
            1: return COEF_MIN;
            2: return '0;
            3: return COEF_ONE;
            4: return -COEF_ONE;
            5: return CW'(1);
            default: return '1;
        endcase
    endfunction

    function automatic void add_write(input int unsigned idx, input logic [CW-1:0] value);
        t_row row;
        row.kind  = ROW_WRITE;
        row.idx   = idx;
        row.value = value;
        row.known = 1'b0;
        row.want  = '0;
        plan.push_back(row);
    endfunction

    function automatic void add_sample(input logic [SW-1:0] smp, input bit known,
                                       input logic [SW-1:0] want);
        t_row row;
        row.kind  = ROW_SAMPLE;
        row.idx   = 0;
        row.value = CW'(smp);
        row.known = known;
        row.want  = want;
        plan.push_back(row);
    endfunction

    // register access: setup cycle, then access until pready
    task automatic apb_access(input bit wr, input int unsigned idx,
                              input logic [PDW-1:0] wdata, output logic [PDW-1:0] rdata);
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= PAW'(idx * 4);
        pwdata  <= wdata;
        @(negedge i_clk) penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        rdata = prdata;
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic send_sample(input logic [SW-1:0] smp, input bit known,
                               input logic [SW-1:0] want);
        int gap;
        gap = (rush || smooth) ? 0 : pick_gap();
        if (gap > 0) begin
            @(negedge i_clk) s_axis_tvalid <= 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
        @(negedge i_clk);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= TDW'(smp);
        next_known = known;
        next_typed = want;
        do @(posedge i_clk); while (!s_axis_tready);
    endtask

    // stop offering, wait for every filtered sample, let the feedback finish
    task automatic drain_results();
        @(negedge i_clk) s_axis_tvalid <= 1'b0;
        while (filtered_q.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic load_setting(input t_coef_style style);
        logic [CW-1:0] vals [biq_pkg::NUM_COEF];
        logic [PDW-1:0] rd;
        int a2;
        int bound;
        for (int i = 0; i < biq_pkg::NUM_COEF; i++) begin
            case (style)
                STYLE_UNITY:   vals[i] = '0;
                STYLE_EXTREME: vals[i] = pick_extreme();
                STYLE_FULL:    vals[i] = CW'($urandom);
                default:       vals[i] = CW'(int'($urandom_range(0, 2 * ONE_Q)) - ONE_Q);
            endcase
        end
        if (style == STYLE_UNITY) begin
            vals[biq_pkg::COEF_FEED_ZERO] = COEF_ONE;
        end else if (style == STYLE_STABLE) begin
            // poles kept inside the stability triangle
            a2    = int'($urandom_range(0, 2 * A2_LIMIT)) - A2_LIMIT;
            bound = (ONE_Q + a2) / 10 * 9;
            vals[biq_pkg::COEF_BACK_TWO] = CW'(a2);
            vals[biq_pkg::COEF_BACK_ONE] = CW'(int'($urandom_range(0, 2 * bound)) - bound);
        end
        for (int i = 0; i < biq_pkg::NUM_COEF; i++) begin
            apb_access(1'b1, i, PDW'(vals[i]), rd);
        end
        for (int i = 0; i < biq_pkg::NUM_COEF; i++) begin
            apb_access(1'b0, i, '0, rd);
            if (rd[CW-1:0] !== tap_coef[i]) begin
                report_mismatch("coefficient readback", rd, PDW'(tap_coef[i]));
            end
        end
    endtask

    // scoreboard: check filtered samples, follow register writes, predict
    always @(posedge i_clk) begin : score
        t_expect head;
        if (i_rst_n) begin
            if (m_axis_tvalid && m_axis_tready) begin
                if (filtered_q.size() == 0) begin
                    report_mismatch("unexpected sample_out", PDW'(m_axis_tdata), '0);
                end else begin
                    head = filtered_q.pop_front();
                    if (m_axis_tdata[SW-1:0] !== head.model) begin
                        report_mismatch("sample_out", PDW'(m_axis_tdata), PDW'(head.model));
                    end
                    if (head.known && m_axis_tdata[SW-1:0] !== head.typed) begin
                        report_mismatch("sample_out vs table", PDW'(m_axis_tdata),
                                        PDW'(head.typed));
                    end
                end
            end
            if (psel && penable && pwrite && pready && (paddr >> 2) < biq_pkg::NUM_COEF) begin
                tap_coef[paddr >> 2] = pwdata[CW-1:0];
            end
            if (s_axis_tvalid && s_axis_tready) begin
                head.model = filter_sample(s_axis_tdata[SW-1:0]);
                head.known = next_known;
                head.typed = next_typed;
                filtered_q.push_back(head);
            end
        end
    end

    // watchdog on cycles with no transfer anywhere
    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
                || (psel && penable)) begin
            idle_cycles = 0;
        end else begin
            idle_cycles++;
        end
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("biquad_iir_filter_unit regression: fail");
            $finish;
        end
    end

    // receiver: random stalls, always ready in smooth mode, one long hold-off on request
    initial begin
        int run_left;
        bit rdy;
        m_axis_tready = 1'b0;
        run_left = 0;
        rdy = 1'b0;
        wait (i_rst_n === 1'b1);
        forever begin
            @(negedge i_clk);
            if (hold_req) begin
                hold_req = 1'b0;
                rdy = 1'b0;
                run_left = HOLD_CYCLES - 1;
            end else if (run_left > 0) begin
                run_left--;
            end else if (smooth) begin
                rdy = 1'b1;
            end else if (rdy) begin
                run_left = pick_gap();
                if (run_left > 0) begin
                    rdy = 1'b0;
                    run_left--;
                end
            end else begin
                rdy = 1'b1;
                run_left = $urandom_range(0, 15);
            end
            m_axis_tready <= rdy;
        end
    end

    // stimulus
    initial begin
        t_row row;
        logic [PDW-1:0] rd;
        t_coef_style style;
        i_rst_n       = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        psel          = 1'b0;
        penable       = 1'b0;
        pwrite        = 1'b0;
        paddr         = '0;
        pwdata        = '0;
        tap_coef[biq_pkg::COEF_FEED_ZERO] = COEF_ONE;
        tap_coef[biq_pkg::COEF_FEED_ONE]  = '0;
        tap_coef[biq_pkg::COEF_FEED_TWO]  = '0;
        tap_coef[biq_pkg::COEF_BACK_ONE]  = '0;
        tap_coef[biq_pkg::COEF_BACK_TWO]  = '0;
        state_one = '0;
        state_two = '0;

        // reset values pass the sample through unchanged
        add_sample(24'h000000, 1'b1, 24'h000000);
        add_sample(SMP_MAX, 1'b1, SMP_MAX);
        add_sample(SMP_MIN, 1'b1, SMP_MIN);
        add_sample(24'h000001, 1'b1, 24'h000001);
        add_sample(24'hFFFFFF, 1'b1, 24'hFFFFFF);
        add_sample(24'h555555, 1'b1, 24'h555555);
        add_sample(24'hAAAAAA, 1'b1, 24'hAAAAAA);
        // largest gain saturates the output
        add_write(biq_pkg::COEF_FEED_ZERO, COEF_MAX);
        add_sample(SMP_MAX, 1'b1, SMP_MAX);
        add_sample(SMP_MIN, 1'b1, SMP_MIN);
        add_sample(24'h000001, 1'b0, '0);
        // most negative gain flips and saturates
        add_write(biq_pkg::COEF_FEED_ZERO, COEF_MIN);
        add_sample(SMP_MAX, 1'b1, SMP_MIN);
        add_sample(SMP_MIN, 1'b1, SMP_MAX);
        add_sample(24'h000000, 1'b1, 24'h000000);
        // writes beyond the last register are ignored
        add_write(biq_pkg::NUM_COEF, '1);
        add_write(LAST_REG_IDX, '1);
        add_sample(24'h400000, 1'b1, SMP_MIN);
        // extreme feedback drives the delay states into saturation
        add_write(biq_pkg::COEF_FEED_ONE, COEF_MAX);
        add_write(biq_pkg::COEF_FEED_TWO, COEF_MIN);
        add_write(biq_pkg::COEF_BACK_ONE, COEF_MIN);
        add_write(biq_pkg::COEF_BACK_TWO, COEF_MAX);
        add_write(biq_pkg::COEF_FEED_ZERO, COEF_ONE);
        repeat (4) add_sample(SMP_MAX, 1'b0, '0);
        repeat (3) add_sample(SMP_MIN, 1'b0, '0);
        // feedback off, saturated states flush out
        add_write(biq_pkg::COEF_BACK_ONE, '0);
        add_write(biq_pkg::COEF_BACK_TWO, '0);
        add_sample(24'h123456, 1'b0, '0);
        add_sample(24'h000000, 1'b0, '0);

        repeat (RESET_CYCLES) @(posedge i_clk);
        @(negedge i_clk) i_rst_n <= 1'b1;

        // directed table
        foreach (plan[i]) begin
            row = plan[i];
            if (row.kind == ROW_WRITE) begin
                drain_results();
                apb_access(1'b1, row.idx, PDW'(row.value), rd);
            end else begin
                send_sample(row.value[SW-1:0], row.known, row.want);
            end
        end

        // random phases, each with its own coefficient setting
        for (int ph = 0; ph < NUM_PHASES; ph++) begin
            case (ph)
                2, 5:    style = STYLE_FULL;
                3, 6:    style = STYLE_EXTREME;
                7:       style = STYLE_UNITY;
                default: style = STYLE_STABLE;
            endcase
            drain_results();
            load_setting(style);
            rush   = (ph == 0);
            smooth = (ph == 1);
            if (ph == 0) begin
                hold_req = 1'b1;
            end
            repeat (PHASE_ITEMS) send_sample(pick_sample(), 1'b0, '0);
            rush   = 1'b0;
            smooth = 1'b0;
        end

        drain_results();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (errors == 0) begin
            $display("biquad_iir_filter_unit regression: pass");
        end else begin
            $display("biquad_iir_filter_unit regression: fail");
        end
        $finish;
    end

endmodule
